FILE: rtl/core/isrt_pkg.sv
// shared constants and types for the insertion sorter
package isrt_pkg;

  // store depth and derived widths
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int SHIFT_W  = 11;

  // input transaction payload
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_item;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
    logic [SHIFT_W-1:0]        shift_count;
    logic                      overflowed;
  } out_item_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic                      valid;
    logic                      greater;
    logic signed [VALUE_W-1:0] value;
  } cell_link_t;

  // broadcast control into the chain
  typedef struct packed {
    logic                      ins_en;
    logic                      drain_en;
    logic signed [VALUE_W-1:0] ins_value;
  } chain_ctl_t;

  // sequencer states
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

endpackage

FILE: rtl/core/isrt_cell.sv
// one compare-and-shift cell of the sorting chain
module isrt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  isrt_pkg::chain_ctl_t ctl,
  input  isrt_pkg::cell_link_t left_link,
  input  isrt_pkg::cell_link_t right_link,
  output isrt_pkg::cell_link_t link,
  output logic                take
);

  logic                               valid_r, valid_nxt;
  logic signed [isrt_pkg::VALUE_W-1:0] value_r, value_nxt;
  logic                               greater;

  // compare against the broadcast value
  assign greater = valid_r && ($signed(value_r) > $signed(ctl.ins_value));

  // new value lands here: first greater cell, or the first empty one
  assign take = !left_link.greater && (greater || (!valid_r && left_link.valid));

  assign link.valid   = valid_r;
  assign link.greater = greater;
  assign link.value   = value_r;

  // next contents: shift up on insert, shift down on drain
  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctl.ins_en) begin
      if (left_link.greater) begin
        valid_nxt = 1'b1;
        value_nxt = left_link.value;
      end else if (take) begin
        valid_nxt = 1'b1;
        value_nxt = ctl.ins_value;
      end
    end else if (ctl.drain_en) begin
      valid_nxt = right_link.valid;
      value_nxt = right_link.value;
    end
  end

  // occupancy bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // stored element
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

FILE: rtl/core/isrt_chain.sv
// row of sorting cells with head access for draining
module isrt_chain (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  isrt_pkg::chain_ctl_t                   ctl,
  output logic [isrt_pkg::CAPACITY-1:0]          take_vec,
  output logic                                   head_valid,
  output logic signed [isrt_pkg::VALUE_W-1:0]    head_value,
  output logic                                   next_valid
);

  isrt_pkg::cell_link_t links [isrt_pkg::CAPACITY];
  isrt_pkg::cell_link_t head_left;
  isrt_pkg::cell_link_t tail_right;

  // boundary links: head sees a filled, never-greater neighbor; tail sees empty
  assign head_left.valid    = 1'b1;
  assign head_left.greater  = 1'b0;
  assign head_left.value    = '0;
  assign tail_right.valid   = 1'b0;
  assign tail_right.greater = 1'b0;
  assign tail_right.value   = '0;

  // cell row
  for (genvar i = 0; i < isrt_pkg::CAPACITY; i++) begin : g_cell
    isrt_pkg::cell_link_t left_in;
    isrt_pkg::cell_link_t right_in;

    if (i == 0) begin : g_head
      assign left_in = head_left;
    end else begin : g_mid_l
      assign left_in = links[i-1];
    end

    if (i == isrt_pkg::CAPACITY - 1) begin : g_tail
      assign right_in = tail_right;
    end else begin : g_mid_r
      assign right_in = links[i+1];
    end

    isrt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .left_link  (left_in),
      .right_link (right_in),
      .link       (links[i]),
      .take       (take_vec[i])
    );
  end

  // head of the row feeds the result channel
  assign head_valid = links[0].valid;
  assign head_value = links[0].value;
  assign next_valid = links[1].valid;

endmodule

FILE: rtl/core/insertion_sorter_with_shift_count.sv
// Streaming insertion sorter: a row of 64 compare-and-shift cells takes one value per cycle
// (in_ready is high during filling), keeps them in ascending order with equal values in
// arrival order, and counts every element moved up. The transaction marked last closes the
// set; the block then drains the row from the head cell, one result per cycle while
// out_ready is high, lowering in_ready until the final result (last_out) is taken. Each
// result carries the set's move total and an overflow flag that is set when items arrived
// while all 64 cells were full; such items are dropped, though a dropped last item still
// closes the set.
module insertion_sorter_with_shift_count (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  isrt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output isrt_pkg::out_item_t out_data
);

  isrt_pkg::state_t                    state_r, state_nxt;
  logic [isrt_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic [isrt_pkg::SHIFT_W-1:0]        total_r, total_nxt;
  logic                                ovf_r, ovf_nxt;

  isrt_pkg::chain_ctl_t                ctl;
  logic [isrt_pkg::CAPACITY-1:0]       take_vec;
  logic                                head_valid;
  logic signed [isrt_pkg::VALUE_W-1:0] head_value;
  logic                                next_valid;

  logic                                in_acc;
  logic                                out_acc;
  logic                                full;
  logic [isrt_pkg::IDX_W-1:0]          pos;
  logic [isrt_pkg::CNT_W-1:0]          moves;

  // cell row
  isrt_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .take_vec   (take_vec),
    .head_valid (head_valid),
    .head_value (head_value),
    .next_valid (next_valid)
  );

  // handshakes
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign full    = (count_r == isrt_pkg::CNT_W'(isrt_pkg::CAPACITY));

  // insertion slot index from the one-hot take vector
  always_comb begin
    pos = '0;
    for (int i = 0; i < isrt_pkg::CAPACITY; i++) begin
      if (take_vec[i]) begin
        pos = pos | isrt_pkg::IDX_W'(i);
      end
    end
  end

  // elements above the slot all move up by one
  assign moves = count_r - isrt_pkg::CNT_W'(pos);

  // result payload straight from the head cell
  assign out_data.sorted_value = head_value;
  assign out_data.last_out     = !next_valid;
  assign out_data.shift_count  = total_r;
  assign out_data.overflowed   = ovf_r;

  // sequencer: next state, counters and chain control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    ctl.ins_en    = 1'b0;
    ctl.drain_en  = 1'b0;
    ctl.ins_value = in_data.value;
    case (state_r)
      isrt_pkg::ST_FILL: begin
        in_ready = 1'b1;
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            ctl.ins_en = 1'b1;
            count_nxt  = count_r + 1'b1;
            total_nxt  = total_r + isrt_pkg::SHIFT_W'(moves);
          end
          if (in_data.last_item) begin
            state_nxt = isrt_pkg::ST_DRAIN;
          end
        end
      end
      isrt_pkg::ST_DRAIN: begin
        out_valid    = 1'b1;
        ctl.drain_en = out_acc;
        if (out_acc && out_data.last_out) begin
          state_nxt = isrt_pkg::ST_FILL;
          count_nxt = '0;
          total_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = isrt_pkg::ST_FILL;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isrt_pkg::ST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  // set bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      total_r <= total_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // at most one cell claims the new value
  a_take_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(take_vec))
    else $error("more than one cell claims the inserted value");

  // a stored insert lands in exactly one cell
  a_take_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |-> $onehot(take_vec))
    else $error("insert with no landing cell");

  // while draining the head cell holds a result
  a_drain_head: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == isrt_pkg::ST_DRAIN |-> head_valid)
    else $error("drain with empty head cell");

  // head occupancy tracks the element count while filling
  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == isrt_pkg::ST_FILL |-> (head_valid == (count_r != '0)))
    else $error("head occupancy disagrees with element count");

  // taking the final result leaves the row empty
  a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_data.last_out |=> !head_valid && count_r == '0)
    else $error("row not empty after final result");

endmodule
